// ----- src/wspm_pkg.sv -----
// shared types, constants and codes for the wheel speed period meter
`timescale 1ns / 1ps

package wspm_pkg;

    localparam int DIV_W      = 34;
    localparam int DVS_W      = 32;
    localparam int DIV_STEPS  = DIV_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [17:0] RPM_MAX           = 18'h3FFFF;
    localparam logic [20:0] SPEED_MAX         = 21'd1118482;
    localparam logic [13:0] RPM_SCALE         = 14'd15360;
    // ceil(2^28 / 15), exact for dividends below 2^24
    localparam logic [24:0] SPEED_RECIP       = 25'd17895698;
    localparam int          SPEED_RECIP_SHIFT = 28;
    localparam int          SPEED_PRE_SHIFT   = 10;

    typedef enum logic [2:0] {
        CFG_TICKS_PER_SECOND = 3'd0,
        CFG_MIN_PERIOD_TICKS = 3'd1,
        CFG_TIMEOUT_TICKS    = 3'd2,
        CFG_STARTUP_TICKS    = 3'd3,
        CFG_CIRCUMFERENCE_MM = 3'd4,
        CFG_FILTER_SHIFT     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [19:0] ticks_per_second;
        logic [31:0] min_period_ticks;
        logic [31:0] timeout_ticks;
        logic [31:0] startup_ticks;
        logic [15:0] circumference_mm;
        logic [3:0]  filter_shift;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RPM_DIV,
        S_FILT,
        S_SPEED_MUL,
        S_SPEED_SCALE,
        S_DONE
    } t_state;

endpackage

// ----- src/wheel_speed_period_meter_top.sv -----
// top level of the wheel speed period meter
`timescale 1ns / 1ps
// Wheel speed period meter.
// Input channel (i_in_valid / o_in_ready) carries one pin sample with its
// 32-bit tick timestamp. Output channel (o_out_valid / i_out_ready) returns
// one result per sample: filtered rpm (Q10.8), speed in mm/s and odometer.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data),
// written by the user while the block is idle; the block does not enforce
// this. Indexes 6 and 7 are ignored. A sample that is not an accepted
// falling edge passes through evaluation, speed multiply and speed scale
// before its result is loaded; an accepted edge first waits on the serial
// divider (one quotient bit per cycle) and the filter. One sample is in work
// at a time, and the next is taken in the cycle after the result is loaded.
// The result sits in an output register; the next sample is taken while it
// waits, and the block holds in its final step if the receiver stalls and
// the register is still full.
// Synchronous active-low reset restores the default configuration, clears
// the rpm average and edge time, and sets the odometer to 1000 mm.

module wheel_speed_period_meter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_pin_level,
    input  logic [31:0] i_now_ticks,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [17:0] o_rpm_filtered,
    output logic [20:0] o_speed_mm_per_s,
    output logic [31:0] o_odometer_mm,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    wspm_pkg::t_cfg     w_cfg;
    wspm_pkg::t_div_req w_div_req;
    wspm_pkg::t_div_rsp w_div_rsp;

    wspm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    wspm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    wspm_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pin_level      (i_pin_level),
        .i_now_ticks      (i_now_ticks),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_rpm_filtered   (o_rpm_filtered),
        .o_speed_mm_per_s (o_speed_mm_per_s),
        .o_odometer_mm    (o_odometer_mm),
        .o_div_req        (w_div_req),
        .i_div_rsp        (w_div_rsp)
    );

endmodule

// ----- src/wspm_cfg.sv -----
// configuration register file
`timescale 1ns / 1ps

module wspm_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output wspm_pkg::t_cfg    o_cfg
);

    wspm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second <= 20'd10000;
            r_cfg.min_period_ticks <= 32'd1100;
            r_cfg.timeout_ticks    <= 32'd30000;
            r_cfg.startup_ticks    <= 32'd40000;
            r_cfg.circumference_mm <= 16'd2200;
            r_cfg.filter_shift     <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (wspm_pkg::t_cfg_idx'(i_cfg_index))
                wspm_pkg::CFG_TICKS_PER_SECOND: r_cfg.ticks_per_second <= i_cfg_data[19:0];
                wspm_pkg::CFG_MIN_PERIOD_TICKS: r_cfg.min_period_ticks <= i_cfg_data;
                wspm_pkg::CFG_TIMEOUT_TICKS:    r_cfg.timeout_ticks    <= i_cfg_data;
                wspm_pkg::CFG_STARTUP_TICKS:    r_cfg.startup_ticks    <= i_cfg_data;
                wspm_pkg::CFG_CIRCUMFERENCE_MM: r_cfg.circumference_mm <= i_cfg_data[15:0];
                wspm_pkg::CFG_FILTER_SHIFT:     r_cfg.filter_shift     <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/wspm_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module wspm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wspm_pkg::t_div_req  i_req,
    output wspm_pkg::t_div_rsp  o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [wspm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [wspm_pkg::DIV_W-1:0]     r_quo;
    logic [wspm_pkg::DVS_W-1:0]     r_rem;
    logic [wspm_pkg::DVS_W-1:0]     r_dvs;

    logic [wspm_pkg::DVS_W:0]       w_rem_sh;
    logic [wspm_pkg::DVS_W:0]       w_rem_nx;
    logic                           w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[wspm_pkg::DIV_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_dvs});
        w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + wspm_pkg::DIV_CNT_W'(1);
                if (r_cnt == wspm_pkg::DIV_CNT_W'(wspm_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[wspm_pkg::DIV_W-2:0], w_ge};
            r_rem <= w_rem_nx[wspm_pkg::DVS_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- src/wspm_ctrl.sv -----
// sequencer, measurement state and result register
`timescale 1ns / 1ps

module wspm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wspm_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_pin_level,
    input  logic [31:0]         i_now_ticks,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [17:0]         o_rpm_filtered,
    output logic [20:0]         o_speed_mm_per_s,
    output logic [31:0]         o_odometer_mm,
    output wspm_pkg::t_div_req  o_div_req,
    input  wspm_pkg::t_div_rsp  i_div_rsp
);

    wspm_pkg::t_state r_state;
    wspm_pkg::t_state n_state;

    logic        r_level;
    logic [31:0] r_now;
    logic        r_prev;
    logic [31:0] r_last;
    logic [17:0] r_avg;
    logic [31:0] r_trip;
    logic [33:0] r_prod;
    logic [48:0] r_scaled;
    logic        r_out_valid;
    logic [17:0] r_out_rpm;
    logic [20:0] r_out_speed;
    logic [31:0] r_out_odo;

    logic [31:0] w_interval;
    logic        w_falling;
    logic        w_edge_ok;
    logic        w_timeout;
    logic [17:0] w_rpm;
    logic        w_avg_hi;
    logic [17:0] w_diff;
    logic [17:0] w_step;
    logic [17:0] w_avg_nx;
    logic [20:0] w_speed_raw;
    logic [20:0] w_speed;
    logic        w_load;
    logic        w_accept;

    always_comb begin
        w_interval = r_now - r_last;
        w_falling  = r_prev & ~r_level;
        w_edge_ok  = w_falling && (w_interval > i_cfg.min_period_ticks);
        w_timeout  = !w_falling && (w_interval > i_cfg.timeout_ticks);

        w_rpm = (i_div_rsp.quotient > 34'(wspm_pkg::RPM_MAX)) ?
                wspm_pkg::RPM_MAX : i_div_rsp.quotient[17:0];
        w_avg_hi = (r_avg >= w_rpm);
        w_diff   = w_avg_hi ? (r_avg - w_rpm) : (w_rpm - r_avg);
        w_step   = w_diff >> i_cfg.filter_shift;
        w_avg_nx = w_avg_hi ? (r_avg - w_step) : (r_avg + w_step);

        w_speed_raw = r_scaled[wspm_pkg::SPEED_RECIP_SHIFT +: 21];
        w_speed     = (w_speed_raw > wspm_pkg::SPEED_MAX) ? wspm_pkg::SPEED_MAX : w_speed_raw;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wspm_pkg::S_IDLE:        if (i_in_valid) n_state = wspm_pkg::S_EVAL;
            wspm_pkg::S_EVAL:        n_state = w_edge_ok ? wspm_pkg::S_RPM_DIV
                                                         : wspm_pkg::S_SPEED_MUL;
            wspm_pkg::S_RPM_DIV:     if (i_div_rsp.done) n_state = wspm_pkg::S_FILT;
            wspm_pkg::S_FILT:        n_state = wspm_pkg::S_SPEED_MUL;
            wspm_pkg::S_SPEED_MUL:   n_state = wspm_pkg::S_SPEED_SCALE;
            wspm_pkg::S_SPEED_SCALE: n_state = wspm_pkg::S_DONE;
            wspm_pkg::S_DONE:        if (!r_out_valid || i_out_ready) n_state = wspm_pkg::S_IDLE;
            default:                 n_state = wspm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready         = 1'b0;
        w_load             = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = 34'(i_cfg.ticks_per_second) * 34'(wspm_pkg::RPM_SCALE);
        o_div_req.divisor  = w_interval;
        unique case (r_state)
            wspm_pkg::S_IDLE: o_in_ready      = 1'b1;
            wspm_pkg::S_EVAL: o_div_req.start = w_edge_ok;
            wspm_pkg::S_DONE: w_load          = !r_out_valid || i_out_ready;
            default: begin
            end
        endcase
        w_accept = i_in_valid && o_in_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wspm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= 1'b0;
            r_last      <= '0;
            r_avg       <= '0;
            r_trip      <= 32'd1000;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == wspm_pkg::S_EVAL) begin
                r_prev <= r_level;
                if (w_edge_ok) begin
                    r_last <= r_now;
                    if (r_now > i_cfg.startup_ticks) begin
                        r_trip <= r_trip + 32'(i_cfg.circumference_mm);
                    end
                end else if (w_timeout) begin
                    r_avg <= '0;
                end
            end
            if (r_state == wspm_pkg::S_FILT) begin
                r_avg <= w_avg_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_level <= i_pin_level;
            r_now   <= i_now_ticks;
        end
        if (r_state == wspm_pkg::S_SPEED_MUL) begin
            r_prod <= 34'(r_avg) * 34'(i_cfg.circumference_mm);
        end
        if (r_state == wspm_pkg::S_SPEED_SCALE) begin
            r_scaled <= 49'(r_prod[33:wspm_pkg::SPEED_PRE_SHIFT]) * 49'(wspm_pkg::SPEED_RECIP);
        end
        if (w_load) begin
            r_out_rpm   <= r_avg;
            r_out_speed <= w_speed;
            r_out_odo   <= r_trip;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_rpm_filtered   = r_out_rpm;
    assign o_speed_mm_per_s = r_out_speed;
    assign o_odometer_mm    = r_out_odo;

endmodule

// ----- bench/tb_wheel_speed_period_meter_top.sv -----
// testbench for the wheel speed period meter, checked against a predictor
`timescale 1ns / 1ps

module tb_wheel_speed_period_meter_top;

    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct {
        logic [17:0] rpm;
        logic [20:0] speed;
        logic [31:0] odo;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_pin_level = 1'b0;
    logic [31:0] i_now_ticks = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [17:0] o_rpm_filtered;
    logic [20:0] o_speed_mm_per_s;
    logic [31:0] o_odometer_mm;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    wheel_speed_period_meter_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pin_level      (i_pin_level),
        .i_now_ticks      (i_now_ticks),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_rpm_filtered   (o_rpm_filtered),
        .o_speed_mm_per_s (o_speed_mm_per_s),
        .o_odometer_mm    (o_odometer_mm),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // predictor state and register shadow
    wspm_pkg::t_cfg cfg_shadow;
    logic        m_prev_level;
    logic [31:0] m_last_edge;
    logic [17:0] m_rpm_avg;
    logic [31:0] m_trip;

    t_reading    exp_readings[$];
    t_reading    chk_want;
    int unsigned err_count = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    int          in_idle_pct = 35;
    int          out_idle_pct = 35;
    logic        valid_held = 1'b0;
    logic [31:0] wheel_time = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_readings.size() == 0) begin
                report_mismatch("unexpected result, odometer", o_odometer_mm, 0);
            end else begin
                chk_want = exp_readings.pop_front();
                if (o_rpm_filtered !== chk_want.rpm)
                    report_mismatch("rpm_filtered", o_rpm_filtered, chk_want.rpm);
                if (o_speed_mm_per_s !== chk_want.speed)
                    report_mismatch("speed_mm_per_s", o_speed_mm_per_s, chk_want.speed);
                if (o_odometer_mm !== chk_want.odo)
                    report_mismatch("odometer_mm", o_odometer_mm, chk_want.odo);
            end
        end
    end

    function automatic void model_reset();
        cfg_shadow.ticks_per_second = 20'd10000;
        cfg_shadow.min_period_ticks = 32'd1100;
        cfg_shadow.timeout_ticks    = 32'd30000;
        cfg_shadow.startup_ticks    = 32'd40000;
        cfg_shadow.circumference_mm = 16'd2200;
        cfg_shadow.filter_shift     = 4'd1;
        m_prev_level = 1'b0;
        m_last_edge  = '0;
        m_rpm_avg    = '0;
        m_trip       = 32'd1000;
    endfunction

    function automatic void predict_reading(input logic lvl, input logic [31:0] t);
        logic [31:0] interval;
        logic [63:0] quot;
        logic [17:0] rpm;
        logic [63:0] speed;
        t_reading    r;
        interval = t - m_last_edge;
        if (m_prev_level && !lvl) begin
            if (interval > cfg_shadow.min_period_ticks) begin
                quot = (64'(wspm_pkg::RPM_SCALE) * 64'(cfg_shadow.ticks_per_second))
                       / 64'(interval);
                rpm = (quot > 64'(wspm_pkg::RPM_MAX)) ? wspm_pkg::RPM_MAX : quot[17:0];
                m_last_edge = t;
                if (m_rpm_avg >= rpm)
                    m_rpm_avg = m_rpm_avg - ((m_rpm_avg - rpm) >> cfg_shadow.filter_shift);
                else
                    m_rpm_avg = m_rpm_avg + ((rpm - m_rpm_avg) >> cfg_shadow.filter_shift);
                if (t > cfg_shadow.startup_ticks)
                    m_trip = m_trip + 32'(cfg_shadow.circumference_mm);
            end
        end else if (interval > cfg_shadow.timeout_ticks) begin
            m_rpm_avg = '0;
        end
        m_prev_level = lvl;
        speed = (64'(m_rpm_avg) * 64'(cfg_shadow.circumference_mm))
                / 64'(wspm_pkg::RPM_SCALE);
        r.rpm   = m_rpm_avg;
        r.speed = (speed > 64'(wspm_pkg::SPEED_MAX)) ? wspm_pkg::SPEED_MAX : speed[20:0];
        r.odo   = m_trip;
        exp_readings.push_back(r);
    endfunction

    task automatic send_sample(input logic lvl, input logic [31:0] t);
        i_in_valid  <= 1'b1;
        i_pin_level <= lvl;
        i_now_ticks <= t;
        do @(posedge i_clk); while (!o_in_ready);
        predict_reading(lvl, t);
        items_sent++;
        @(negedge i_clk);
        valid_held = 1'b1;
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            valid_held = 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
    endtask

    // drop valid and let every pending result drain
    task automatic quiesce();
        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held = 1'b0;
            @(negedge i_clk);
        end
        while (exp_readings.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input wspm_pkg::t_cfg_idx idx, input logic [31:0] data);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            wspm_pkg::CFG_TICKS_PER_SECOND: cfg_shadow.ticks_per_second = data[19:0];
            wspm_pkg::CFG_MIN_PERIOD_TICKS: cfg_shadow.min_period_ticks = data;
            wspm_pkg::CFG_TIMEOUT_TICKS:    cfg_shadow.timeout_ticks    = data;
            wspm_pkg::CFG_STARTUP_TICKS:    cfg_shadow.startup_ticks    = data;
            wspm_pkg::CFG_CIRCUMFERENCE_MM: cfg_shadow.circumference_mm = data[15:0];
            wspm_pkg::CFG_FILTER_SHIFT:     cfg_shadow.filter_shift     = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic randomize_setup();
        logic [31:0] tps;
        logic [31:0] min_p;
        logic [31:0] tmo;
        tps   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000000)
                                             : $urandom_range(500, 20000);
        min_p = $urandom_range(0, 3000);
        tmo   = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom_range(min_p, 80000);
        write_reg(wspm_pkg::CFG_TICKS_PER_SECOND, tps);
        write_reg(wspm_pkg::CFG_MIN_PERIOD_TICKS, min_p);
        write_reg(wspm_pkg::CFG_TIMEOUT_TICKS, tmo);
        write_reg(wspm_pkg::CFG_STARTUP_TICKS, wheel_time + $urandom_range(0, 60000));
        write_reg(wspm_pkg::CFG_CIRCUMFERENCE_MM, $urandom_range(0, 65535));
        write_reg(wspm_pkg::CFG_FILTER_SHIFT, $urandom_range(0, 15));
    endtask

    function automatic logic [31:0] pick_period();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return cfg_shadow.min_period_ticks + $urandom_range(0, 2);
        if (r < 25)
            return cfg_shadow.timeout_ticks + $urandom_range(1, 20000);
        return $urandom_range(1, 20000);
    endfunction

    // one wheel turn: pin high half way, falling edge at the end
    task automatic spin(input logic [31:0] period);
        send_sample(1'b1, wheel_time + (period >> 1));
        if ($urandom_range(0, 9) == 0)
            send_sample(1'b1, wheel_time + (period >> 1) + 1);
        wheel_time = wheel_time + period;
        send_sample(1'b0, wheel_time);
        if ($urandom_range(0, 9) == 0) begin
            send_sample(1'b1, wheel_time + 1);
            send_sample(1'b0, wheel_time + 2);
        end
    endtask

    task automatic run_traffic(input int unsigned target);
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 12)
                send_sample($urandom_range(0, 1), $urandom());
            else
                spin(pick_period());
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(1'b0, 32'd0);
        send_sample(1'b1, 32'd5000);
        send_sample(1'b0, 32'd10000);
        send_sample(1'b1, 32'd10500);
        send_sample(1'b0, 32'd11000);
        send_sample(1'b1, 32'd11050);
        send_sample(1'b0, 32'd11100);
        send_sample(1'b0, 32'd45000);
        send_sample(1'b1, 32'd45500);
        send_sample(1'b0, 32'd46000);
        wheel_time = 32'd46000;
    endtask

    task automatic test_field_extremes();
        write_reg(wspm_pkg::CFG_TICKS_PER_SECOND, 32'd1000000);
        write_reg(wspm_pkg::CFG_MIN_PERIOD_TICKS, 32'd0);
        write_reg(wspm_pkg::CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
        write_reg(wspm_pkg::CFG_STARTUP_TICKS, 32'd0);
        write_reg(wspm_pkg::CFG_CIRCUMFERENCE_MM, 32'd65535);
        write_reg(wspm_pkg::CFG_FILTER_SHIFT, 32'd0);
        send_sample(1'b1, 32'hFFFF_FFF0);
        send_sample(1'b0, 32'hFFFF_FFFF);
        // timestamp wraps, short interval saturates rpm
        send_sample(1'b1, 32'd0);
        send_sample(1'b0, 32'd1);
        send_sample(1'b0, 32'd2);
        // zero tick rate with the largest shift
        write_reg(wspm_pkg::CFG_TICKS_PER_SECOND, 32'd0);
        write_reg(wspm_pkg::CFG_FILTER_SHIFT, 32'd15);
        send_sample(1'b1, 32'd5);
        send_sample(1'b0, 32'd6);
        write_reg(wspm_pkg::CFG_MIN_PERIOD_TICKS, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'd7);
        send_sample(1'b0, 32'd100);
        write_reg(wspm_pkg::CFG_TIMEOUT_TICKS, 32'd0);
        write_reg(wspm_pkg::CFG_MIN_PERIOD_TICKS, 32'd0);
        write_reg(wspm_pkg::CFG_STARTUP_TICKS, 32'hFFFF_FFFF);
        write_reg(wspm_pkg::CFG_TICKS_PER_SECOND, 32'd1000);
        write_reg(wspm_pkg::CFG_FILTER_SHIFT, 32'd8);
        write_reg(wspm_pkg::CFG_CIRCUMFERENCE_MM, 32'd0);
        send_sample(1'b0, 32'd200);
        send_sample(1'b1, 32'd300);
        send_sample(1'b0, 32'd1000);
        wheel_time = 32'd1000;
    endtask

    task automatic test_random_rides();
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 2)
                wheel_time = 32'hFFFF_0000 + $urandom_range(0, 4096);
            randomize_setup();
            run_traffic(items_sent + 130);
        end
    endtask

    task automatic test_back_to_back();
        randomize_setup();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_traffic(items_sent + 80);
        quiesce();
        in_idle_pct  = 35;
        out_idle_pct = 35;
    endtask

    task automatic test_drain_pause();
        randomize_setup();
        run_traffic(items_sent + 30);
        quiesce();
        run_traffic(items_sent + 30);
    endtask

    initial begin
        model_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_field_extremes();
        test_random_rides();
        test_back_to_back();
        test_drain_pause();
        quiesce();
        repeat (50) @(posedge i_clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/wspm_pkg.sv
src/wspm_cfg.sv
src/wspm_div.sv
src/wspm_ctrl.sv
src/wheel_speed_period_meter_top.sv
bench/tb_wheel_speed_period_meter_top.sv
